### rtl/core/brmm_pkg.sv
// ----------------------------------------------------------------------------
// brmm_pkg
// Shared types and constants of the block RMS and mean meter: sequencer
// states, register indexes, input function codes and iteration counts.
// ----------------------------------------------------------------------------
`default_nettype none

package brmm_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_BLOCK_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_LENGTH_RECIP  = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_SIGNED = 2'd2;

  // Input function codes carried on tuser.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Both the shift-add multiplier and the square root take one bit (or one
  // root bit) per cycle, over a 32-bit multiplier or a 64-bit radicand.
  localparam int unsigned   ITERS     = 32;
  localparam int unsigned   ITER_W    = 5;
  localparam logic [4:0]    ITER_LAST = 5'(ITERS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_MEAN,
    S_MEAN_FIN,
    S_MUL_MS,
    S_MS_FIN,
    S_ROOT_MS,
    S_RMS_FIN,
    S_MUL_SQ,
    S_DIFF,
    S_NEGDIFF,
    S_ROOT_AC,
    S_AC_FIN,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/block_rms_mean_meter.sv
// ----------------------------------------------------------------------------
// block_rms_mean_meter
// Accumulates the sum and the sum of squares of 16-bit samples over blocks of
// a configured length and, at the end of each block, computes the mean, the
// RMS and the AC RMS in Q.8 fixed point with one shared adder.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  --------  ---------  ------------------------------------------------------
//  s_*       in         tuser: func (clear); tdata: sample
//  m_*       out        tuser: block_done; tdata: mean, rms, rms_ac
//  cfg_*     in         write enable, register index, write data
//
// An ordinary sample or a clear is handled in the idle state, and such beats go
// through back to back as long as the output side keeps taking results. A
// sample that completes a block runs the sequencer: four passes (mean product,
// mean square product, RMS root, squared mean product), a fifth for the AC
// root, and six further steps, seven when the variance comes out negative,
// before the result beat is loaded into the output register.
// All of it runs through the one 64-bit adder below. Reset is synchronous and
// restores the default registers and zero accumulators. A stalled output holds
// the result in its register; the block waits before its next beat only if a
// second result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module block_rms_mean_meter #(
  parameter int unsigned MAX_BLOCK_LENGTH = 65536,
  parameter int unsigned RESULT_FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] sample
  input  wire logic        s_tuser,   // [0] func
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // [24:0] mean_out, [48:25] rms_out,
                                      // [73:49] rms_ac_out, [79:74] zero
  output logic             m_tuser,   // [0] block_done
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  // Sample counter width; it wraps at MAX_BLOCK_LENGTH.
  localparam int unsigned CNT_W  = (MAX_BLOCK_LENGTH > 1) ? $clog2(MAX_BLOCK_LENGTH) : 1;
  localparam int unsigned CNT1_W = CNT_W + 1;
  localparam int unsigned CMP_W  = (CNT1_W > 17) ? CNT1_W : 17;
  localparam logic [CNT_W:0] MAX_CNT = CNT1_W'(MAX_BLOCK_LENGTH);

  // Product and rescaling widths. The rescale shifts left by up to 2*16 bits.
  localparam int unsigned PROD_W  = 80;
  localparam int unsigned SCALE_W = PROD_W + 32;

  // Saturation limits of the results.
  localparam longint unsigned TOP_RAW = 64'd65535 << RESULT_FRAC_BITS;
  localparam longint unsigned LOW_RAW = 64'd32768 << RESULT_FRAC_BITS;
  localparam logic [24:0] RES_TOP =
    (TOP_RAW > 64'h0FF_FFFF) ? 25'h0FF_FFFF : 25'(TOP_RAW);
  localparam logic [24:0] RES_LOW =
    (LOW_RAW > 64'h100_0000) ? 25'h100_0000 : 25'(LOW_RAW);
  localparam logic [62:0] ICAP = {1'b1, 62'd0};

  // Configuration registers.
  logic [16:0] block_length;
  logic [31:0] length_recip;
  logic        sample_signed;

  // Architectural state.
  logic [CNT_W-1:0] sample_count;
  logic [33:0]      running_sum;
  logic [47:0]      running_square_sum;
  logic [24:0]      held_mean;
  logic [23:0]      held_rms;
  logic [24:0]      held_rms_ac;

  // Sequencer and working registers.
  brmm_pkg::state_t            state, state_next;
  logic [brmm_pkg::ITER_W-1:0] iter;
  logic [47:0]                 mul_a;
  logic [PROD_W-1:0]           prod;
  logic                        mean_neg;
  logic [24:0]                 mmag;
  logic [62:0]                 ms;
  logic [63:0]                 rad;
  logic [34:0]                 rem;
  logic [31:0]                 root;
  logic                        ac_neg;
  logic                        emit_done;

  // Shared adder.
  logic [63:0] alu_a, alu_b, alu_sum;
  logic        alu_cin;

  logic in_accept, is_clear, blk_done, out_free, out_load, iter_last;

  // Sample intake.
  logic signed [16:0] sval;
  logic [15:0]        smag;
  logic [31:0]        ssq;
  logic [33:0]        sum_new, sum_mag;
  logic [47:0]        sq_new;
  logic [CNT_W:0]     cnt_next;
  logic [CNT_W-1:0]   cnt_wrap;

  // Block-end arithmetic.
  logic [SCALE_W-1:0] mean_scaled, ms_scaled;
  logic [24:0]        mean_lim, mean_sat, ac_mag;
  logic [62:0]        ms_sat;
  logic [34:0]        rem_sh, trial;
  logic               root_take;

  assign in_accept = s_tvalid && s_tready;
  assign is_clear  = (s_tuser == brmm_pkg::FUNC_CLEAR);
  assign out_free  = !m_tvalid || m_tready;
  assign iter_last = (iter == brmm_pkg::ITER_LAST);

  // A sample is read as two's complement only when the register says so.
  assign sval    = {sample_signed & s_tdata[15], s_tdata};
  assign smag    = sval[16] ? 16'(17'sd0 - sval) : s_tdata;
  assign ssq     = smag * smag;
  assign sum_new = running_sum + {{17{sval[16]}}, sval};
  assign sq_new  = running_square_sum + {16'd0, ssq};
  assign sum_mag = sum_new[33] ? 34'(34'd0 - sum_new) : sum_new;

  assign cnt_next = {1'b0, sample_count} + CNT1_W'(1);
  assign blk_done = (CMP_W'(cnt_next) == CMP_W'(block_length));
  assign cnt_wrap = (cnt_next == MAX_CNT) ? '0 : cnt_next[CNT_W-1:0];

  // Rescale the Q49.31 products to Q.F (mean) and Q.2F (mean square). A
  // negative mean saturates at 32768 in magnitude, a positive one at 65535.
  assign mean_scaled = (SCALE_W'(prod) << RESULT_FRAC_BITS) >> 31;
  assign ms_scaled   = (SCALE_W'(prod) << (2 * RESULT_FRAC_BITS)) >> 31;
  assign mean_lim    = mean_neg ? RES_LOW : RES_TOP;
  assign mean_sat    = (mean_scaled > SCALE_W'(mean_lim)) ? mean_lim : mean_scaled[24:0];
  assign ms_sat      = (ms_scaled > SCALE_W'(ICAP)) ? ICAP : ms_scaled[62:0];
  assign ac_mag      = ({8'd0, RES_TOP} < {1'b0, root}) ? RES_TOP : root[24:0];

  // Square root step: bring down two radicand bits and try the next root bit.
  assign rem_sh    = {rem[32:0], rad[63:62]};
  assign trial     = {1'b0, root, 2'b01};
  assign root_take = !alu_sum[63];

  assign alu_sum = alu_a + alu_b + 64'(alu_cin);

  assign out_load = (state == brmm_pkg::S_IDLE && in_accept && (is_clear || !blk_done)
                     && out_free)
                 || (state == brmm_pkg::S_EMIT && out_free);

  // Sequencer next state and adder operand selection.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    alu_a      = '0;
    alu_b      = '0;
    alu_cin    = 1'b0;
    case (state)
      brmm_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (in_accept) begin
          if (!is_clear && blk_done) begin
            state_next = brmm_pkg::S_MUL_MEAN;
          end else if (!out_free) begin
            state_next = brmm_pkg::S_EMIT;
          end
        end
      end
      brmm_pkg::S_MUL_MEAN, brmm_pkg::S_MUL_MS, brmm_pkg::S_MUL_SQ: begin
        // One multiplier bit per cycle: add the multiplicand into the upper 48 bits.
        alu_a = {16'd0, prod[79:32]};
        alu_b = prod[0] ? {16'd0, mul_a} : '0;
        if (iter_last) begin
          case (state)
            brmm_pkg::S_MUL_MEAN: state_next = brmm_pkg::S_MEAN_FIN;
            brmm_pkg::S_MUL_MS:   state_next = brmm_pkg::S_MS_FIN;
            default:              state_next = brmm_pkg::S_DIFF;
          endcase
        end
      end
      brmm_pkg::S_MEAN_FIN: state_next = brmm_pkg::S_MUL_MS;
      brmm_pkg::S_MS_FIN:   state_next = brmm_pkg::S_ROOT_MS;
      brmm_pkg::S_ROOT_MS, brmm_pkg::S_ROOT_AC: begin
        alu_a   = {29'd0, rem_sh};
        alu_b   = ~{29'd0, trial};
        alu_cin = 1'b1;
        if (iter_last) begin
          state_next = (state == brmm_pkg::S_ROOT_MS) ? brmm_pkg::S_RMS_FIN
                                                      : brmm_pkg::S_AC_FIN;
        end
      end
      brmm_pkg::S_RMS_FIN: state_next = brmm_pkg::S_MUL_SQ;
      brmm_pkg::S_DIFF: begin
        // Mean square minus the squared mean; a borrow sends us to negate.
        alu_a      = {1'b0, ms};
        alu_b      = ~prod[63:0];
        alu_cin    = 1'b1;
        state_next = alu_sum[63] ? brmm_pkg::S_NEGDIFF : brmm_pkg::S_ROOT_AC;
      end
      brmm_pkg::S_NEGDIFF: begin
        alu_a      = prod[63:0];
        alu_b      = ~{1'b0, ms};
        alu_cin    = 1'b1;
        state_next = brmm_pkg::S_ROOT_AC;
      end
      brmm_pkg::S_AC_FIN: state_next = brmm_pkg::S_EMIT;
      brmm_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = brmm_pkg::S_IDLE;
        end
      end
      default: state_next = brmm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brmm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length  <= 17'd1024;
      length_recip  <= 32'd2097152;
      sample_signed <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        brmm_pkg::CFG_BLOCK_LENGTH:  block_length  <= cfg_wdata[16:0];
        brmm_pkg::CFG_LENGTH_RECIP:  length_recip  <= cfg_wdata;
        brmm_pkg::CFG_SAMPLE_SIGNED: sample_signed <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Accumulators, counter and held results. On a completing sample the
  // square sum is parked in its own register until the mean step copies it
  // into the multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count       <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      held_mean          <= '0;
      held_rms           <= '0;
      held_rms_ac        <= '0;
    end else begin
      if (in_accept) begin
        if (is_clear) begin
          sample_count       <= '0;
          running_sum        <= '0;
          running_square_sum <= '0;
          held_mean          <= '0;
          held_rms           <= '0;
          held_rms_ac        <= '0;
        end else if (blk_done) begin
          sample_count       <= '0;
          running_sum        <= '0;
          running_square_sum <= sq_new;
        end else begin
          sample_count       <= cnt_wrap;
          running_sum        <= sum_new;
          running_square_sum <= sq_new;
        end
      end
      if (state == brmm_pkg::S_MEAN_FIN) begin
        held_mean          <= mean_neg ? 25'(25'd0 - mean_sat) : mean_sat;
        running_square_sum <= '0;
      end
      if (state == brmm_pkg::S_RMS_FIN) begin
        held_rms <= ac_mag[23:0];
      end
      if (state == brmm_pkg::S_AC_FIN) begin
        held_rms_ac <= ac_neg ? 25'(25'd0 - ac_mag) : ac_mag;
      end
    end
  end

  // Working registers of the shared multiplier and square root.
  always_ff @(posedge clk) begin
    case (state)
      brmm_pkg::S_IDLE: begin
        emit_done <= 1'b0;
        if (in_accept && !is_clear && blk_done) begin
          mul_a    <= {14'd0, sum_mag};
          prod     <= {48'd0, length_recip};
          mean_neg <= sum_new[33];
          iter     <= '0;
        end
      end
      brmm_pkg::S_MUL_MEAN, brmm_pkg::S_MUL_MS, brmm_pkg::S_MUL_SQ: begin
        prod <= {alu_sum[48:0], prod[31:1]};
        iter <= iter + 1'b1;
      end
      brmm_pkg::S_MEAN_FIN: begin
        mmag  <= mean_sat;
        mul_a <= running_square_sum;
        prod  <= {48'd0, length_recip};
        iter  <= '0;
      end
      brmm_pkg::S_MS_FIN: begin
        ms   <= ms_sat;
        rad  <= {1'b0, ms_sat};
        rem  <= '0;
        root <= '0;
        iter <= '0;
      end
      brmm_pkg::S_ROOT_MS, brmm_pkg::S_ROOT_AC: begin
        rem  <= root_take ? alu_sum[34:0] : rem_sh;
        root <= {root[30:0], root_take};
        rad  <= {rad[61:0], 2'b00};
        iter <= iter + 1'b1;
      end
      brmm_pkg::S_RMS_FIN: begin
        mul_a <= {23'd0, mmag};
        prod  <= {48'd0, 7'd0, mmag};
        iter  <= '0;
      end
      brmm_pkg::S_DIFF, brmm_pkg::S_NEGDIFF: begin
        ac_neg <= (state == brmm_pkg::S_NEGDIFF);
        rad    <= alu_sum;
        rem    <= '0;
        root   <= '0;
        iter   <= '0;
      end
      brmm_pkg::S_AC_FIN: emit_done <= 1'b1;
      default: ;
    endcase
  end

  // Output register. A direct load from the idle state carries a sample that
  // did not end a block (held results unchanged) or a clear (all zero).
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == brmm_pkg::S_IDLE && is_clear) begin
        m_tdata <= '0;
        m_tuser <= 1'b0;
      end else begin
        m_tdata <= {6'd0, held_rms_ac, held_rms, held_mean};
        m_tuser <= (state == brmm_pkg::S_EMIT) && emit_done;
      end
    end
  end

endmodule

`default_nettype wire
